>>> src/orlt_pkg.sv
`default_nettype none

package orlt_pkg;

   // list depth and the widths that follow from it
   localparam int CAPACITY = 256;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // stream word widths
   localparam int REQ_TDATA_W = 80;
   localparam int REQ_TUSER_W = 4;
   localparam int RSP_TDATA_W = 96;

   // operation codes carried on req_tuser
   localparam logic [3:0] MODE_INS_FRONT = 4'd0;
   localparam logic [3:0] MODE_INS_END   = 4'd1;
   localparam logic [3:0] MODE_INS_AT    = 4'd2;
   localparam logic [3:0] MODE_RM_FRONT  = 4'd3;
   localparam logic [3:0] MODE_RM_END    = 4'd4;
   localparam logic [3:0] MODE_RM_AT     = 4'd5;
   localparam logic [3:0] MODE_RM_KEY    = 4'd6;
   localparam logic [3:0] MODE_FIND      = 4'd7;
   localparam logic [3:0] MODE_READ      = 4'd8;
   localparam logic [3:0] MODE_CLEAR     = 4'd9;

   // result status codes
   localparam logic [2:0] STAT_OK     = 3'd0;
   localparam logic [2:0] STAT_EMPTY  = 3'd1;
   localparam logic [2:0] STAT_BADPOS = 3'd2;
   localparam logic [2:0] STAT_FULL   = 3'd3;
   localparam logic [2:0] STAT_NOKEY  = 3'd4;

   // one stored record
   typedef struct packed {
      logic [31:0]        payload;
      logic signed [31:0] key;
   } entry_type;

endpackage

`default_nettype wire

>>> src/ordered_record_list_table_unit.sv
// channel   dir  ports                              word contents
// req       in   req_tvalid/req_tready/req_tdata    position, item_key, item_payload
//                req_tuser                          mode
// rsp       out  rsp_tvalid/rsp_tready/rsp_tdata    status, found_index, key_out,
//                                                   payload_out, match_count,
//                                                   list_size, is_empty
//
// one request at a time; records live in a single 256 x 64 synchronous ram
// with one write and one read port, and every shift or search walks it one
// entry per cycle, so a walk grows with the number of stored entries;
// clear, unused codes and error cases skip the walk
// reset is synchronous and clears the state, the entry count, the read flags and the handshakes only
// a finished result waits in the output register; the next request is taken
// while it waits, and the unit holds in the finish state if the old one is unread
`default_nettype none

module ordered_record_list_table_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [15:0] position, [47:16] item_key, [79:48] item_payload
   input  wire logic [orlt_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [3:0] mode
   input  wire logic [orlt_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [2:0] status, [10:3] found_index, [42:11] key_out, [74:43] payload_out,
   // [83:75] match_count, [92:84] list_size, [93] is_empty, [95:94] zero
   output logic [orlt_pkg::RSP_TDATA_W-1:0]         rsp_tdata
);
   import orlt_pkg::*;

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;
   localparam logic [1:0] ST_FIN   = 2'd3;

   // record store
   entry_type mem [CAPACITY];
   entry_type rdata_ff;

   // control state
   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             iss_ff, iss_in;      // reads still to be issued
   logic             pv_ff, pv_in;        // read data arrives this cycle
   logic             rsp_tvalid_ff;

   // operation context
   logic [3:0]         mode_ff, mode_in;
   logic signed [31:0] key_ff, key_in;
   logic [31:0]        pay_ff, pay_in;
   logic [IDX_W-1:0]   at_ff, at_in;
   logic [IDX_W-1:0]   rd_ff, rd_in;
   logic [IDX_W-1:0]   end_ff, end_in;
   logic               up_ff, up_in;
   logic [IDX_W-1:0]   pa_ff, pa_in;
   logic [CNT_W-1:0]   w_ff, w_in;
   logic               found_ff, found_in;

   // result under construction
   logic [2:0]       stat_ff, stat_in;
   logic [IDX_W-1:0] fidx_ff, fidx_in;
   logic [31:0]      kout_ff, kout_in;
   logic [31:0]      pout_ff, pout_in;
   logic [CNT_W-1:0] mcnt_ff, mcnt_in;

   logic [RSP_TDATA_W-1:0] rsp_tdata_ff;

   // ram port controls
   logic             ren;
   logic [IDX_W-1:0] raddr;
   logic             wen;
   logic [IDX_W-1:0] waddr;
   entry_type        wdata;

   // request fields
   logic [3:0]         req_mode;
   logic [15:0]        req_position;
   logic signed [31:0] req_key;
   logic [31:0]        req_payload;
   logic               pos_lt;
   logic [CNT_W-1:0]   ins_at;
   logic [CNT_W-1:0]   drop_at;
   logic [CNT_W-1:0]   last_idx;
   logic               load_rsp;

   assign req_mode     = req_tuser[3:0];
   assign req_position = req_tdata[15:0];
   assign req_key      = signed'(req_tdata[47:16]);
   assign req_payload  = req_tdata[79:48];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign load_rsp = (state_ff == ST_FIN) && (!rsp_tvalid_ff || rsp_tready);

   // position clamping: past the end appends, or removes the last entry
   assign pos_lt   = (req_position < 16'(count_ff));
   assign last_idx = count_ff - 1'b1;

   always_comb begin
      case (req_mode)
         MODE_INS_FRONT: ins_at = '0;
         MODE_INS_END:   ins_at = count_ff;
         default:        ins_at = pos_lt ? CNT_W'(req_position) : count_ff;
      endcase
      case (req_mode)
         MODE_RM_FRONT: drop_at = '0;
         MODE_RM_END:   drop_at = last_idx;
         default:       drop_at = pos_lt ? CNT_W'(req_position) : last_idx;
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      iss_in   = iss_ff;
      pv_in    = 1'b0;
      mode_in  = mode_ff;
      key_in   = key_ff;
      pay_in   = pay_ff;
      at_in    = at_ff;
      rd_in    = rd_ff;
      end_in   = end_ff;
      up_in    = up_ff;
      pa_in    = pa_ff;
      w_in     = w_ff;
      found_in = found_ff;
      stat_in  = stat_ff;
      fidx_in  = fidx_ff;
      kout_in  = kout_ff;
      pout_in  = pout_ff;
      mcnt_in  = mcnt_ff;
      ren      = 1'b0;
      raddr    = rd_ff;
      wen      = 1'b0;
      waddr    = '0;
      wdata    = rdata_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in  = req_mode;
               key_in   = req_key;
               pay_in   = req_payload;
               stat_in  = STAT_OK;
               fidx_in  = '0;
               kout_in  = '0;
               pout_in  = '0;
               mcnt_in  = '0;
               w_in     = '0;
               found_in = 1'b0;
               iss_in   = 1'b1;
               state_in = ST_FIN;
               case (req_mode)
                  MODE_INS_FRONT, MODE_INS_END, MODE_INS_AT: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        stat_in = STAT_FULL;
                     end else begin
                        at_in = IDX_W'(ins_at);
                        if (ins_at == count_ff) begin
                           state_in = ST_WRITE;
                        end else begin
                           // shift up from the top entry down to the slot
                           rd_in    = IDX_W'(last_idx);
                           end_in   = IDX_W'(ins_at);
                           up_in    = 1'b0;
                           state_in = ST_SCAN;
                        end
                     end
                  end
                  MODE_RM_FRONT, MODE_RM_END, MODE_RM_AT: begin
                     if (count_ff == '0) begin
                        stat_in = STAT_EMPTY;
                     end else if (drop_at == last_idx) begin
                        count_in = last_idx;
                     end else begin
                        // pull entries above the slot down by one
                        rd_in    = IDX_W'(drop_at + 1'b1);
                        end_in   = IDX_W'(last_idx);
                        up_in    = 1'b1;
                        state_in = ST_SCAN;
                     end
                  end
                  MODE_RM_KEY, MODE_FIND: begin
                     if (count_ff == '0) begin
                        stat_in = STAT_EMPTY;
                     end else begin
                        rd_in    = '0;
                        end_in   = IDX_W'(last_idx);
                        up_in    = 1'b1;
                        state_in = ST_SCAN;
                     end
                  end
                  MODE_READ: begin
                     if (count_ff == '0) begin
                        stat_in = STAT_EMPTY;
                     end else if (!pos_lt) begin
                        stat_in = STAT_BADPOS;
                     end else begin
                        rd_in    = IDX_W'(req_position);
                        end_in   = IDX_W'(req_position);
                        up_in    = 1'b1;
                        state_in = ST_SCAN;
                     end
                  end
                  MODE_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // issue side: one read per cycle
            if (iss_ff) begin
               ren   = 1'b1;
               pv_in = 1'b1;
               pa_in = rd_ff;
               if (rd_ff == end_ff) begin
                  iss_in = 1'b0;
               end else begin
                  rd_in = up_ff ? rd_ff + 1'b1 : rd_ff - 1'b1;
               end
            end
            // data side: act on the entry read last cycle
            if (pv_ff) begin
               case (mode_ff)
                  MODE_INS_FRONT, MODE_INS_END, MODE_INS_AT: begin
                     wen   = 1'b1;
                     waddr = pa_ff + 1'b1;
                  end
                  MODE_RM_FRONT, MODE_RM_END, MODE_RM_AT: begin
                     wen   = 1'b1;
                     waddr = pa_ff - 1'b1;
                  end
                  MODE_RM_KEY: begin
                     if (rdata_ff.key == key_ff) begin
                        mcnt_in = mcnt_ff + 1'b1;
                     end else begin
                        // compact survivors toward the front
                        wen   = 1'b1;
                        waddr = IDX_W'(w_ff);
                        w_in  = w_ff + 1'b1;
                     end
                  end
                  MODE_FIND: begin
                     if (rdata_ff.key == key_ff && !found_ff) begin
                        found_in = 1'b1;
                        fidx_in  = pa_ff;
                        kout_in  = rdata_ff.key;
                        pout_in  = rdata_ff.payload;
                     end
                  end
                  MODE_READ: begin
                     kout_in = rdata_ff.key;
                     pout_in = rdata_ff.payload;
                  end
                  default: begin
                  end
               endcase
            end
            // walk done and last data consumed
            if (!iss_ff && !pv_ff) begin
               state_in = ST_FIN;
               case (mode_ff)
                  MODE_INS_FRONT, MODE_INS_END, MODE_INS_AT: begin
                     state_in = ST_WRITE;
                  end
                  MODE_RM_FRONT, MODE_RM_END, MODE_RM_AT: begin
                     count_in = last_idx;
                  end
                  MODE_RM_KEY: begin
                     count_in = w_ff;
                     if (mcnt_ff == '0) begin
                        stat_in = STAT_NOKEY;
                     end
                  end
                  MODE_FIND: begin
                     if (!found_ff) begin
                        stat_in = STAT_NOKEY;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_WRITE: begin
            // new record into the opened slot
            wen           = 1'b1;
            waddr         = at_ff;
            wdata.key     = key_ff;
            wdata.payload = pay_ff;
            count_in      = count_ff + 1'b1;
            state_in      = ST_FIN;
         end

         ST_FIN: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // record ram, registered read
   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      if (ren) begin
         rdata_ff <= mem[raddr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         iss_ff        <= 1'b0;
         pv_ff         <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         iss_ff   <= iss_in;
         pv_ff    <= pv_in;
         if (load_rsp) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // operation context and result registers
   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      key_ff   <= key_in;
      pay_ff   <= pay_in;
      at_ff    <= at_in;
      rd_ff    <= rd_in;
      end_ff   <= end_in;
      up_ff    <= up_in;
      pa_ff    <= pa_in;
      w_ff     <= w_in;
      found_ff <= found_in;
      stat_ff  <= stat_in;
      fidx_ff  <= fidx_in;
      kout_ff  <= kout_in;
      pout_ff  <= pout_in;
      mcnt_ff  <= mcnt_in;
      if (load_rsp) begin
         rsp_tdata_ff <= {2'b00,
                          (count_ff == '0),
                          9'(count_ff),
                          9'(mcnt_ff),
                          pout_ff,
                          kout_ff,
                          8'(fidx_ff),
                          stat_ff};
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wen |-> CNT_W'(waddr) <= count_ff)
      else $error("ram write beyond the list end");

   a_read_data_in_scan: assert property (@(posedge clock) disable iff (reset)
      pv_ff |-> state_ff == ST_SCAN)
      else $error("read data outside a walk");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff) == ST_FIN)
      else $error("result raised outside finish");

   a_fin_loads: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_tvalid_ff && state_ff == ST_IDLE)
      else $error("finished result not presented");
`endif

endmodule

`default_nettype wire

>>> bench/ordered_record_list_table_unit_test.sv
`default_nettype none

module ordered_record_list_table_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import orlt_pkg::*;

   // codes left unused by the unit, they must come back as a plain ok
   localparam logic [3:0] MODE_UNUSED_LO = 4'd10;
   localparam logic [3:0] MODE_UNUSED_HI = 4'd15;

   // one result word, split into its fields
   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  found_index;
      logic [31:0] key_out;
      logic [31:0] payload_out;
      logic [8:0]  match_count;
      logic [8:0]  list_size;
      logic        is_empty;
   } list_result_type;

   // one row of the directed table
   typedef struct {
      logic [3:0]      mode;
      logic [15:0]     pos;
      logic [31:0]     key;
      logic [31:0]     pay;
      bit              typed;
      list_result_type want;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   ordered_record_list_table_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // shadow copy of the list, updated as each request word is taken
   logic [31:0]  shadow_keys [CAPACITY];
   logic [31:0]  shadow_pays [CAPACITY];
   int           shadow_count = 0;

   list_result_type pending_results [$];
   int              mismatch_count = 0;
   int              words_checked = 0;
   int              req_calm = 0;
   int              rsp_calm = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at result %0d: %s got %h want %h",
               words_checked, what, got, want);
      mismatch_count++;
   endtask

   // idle length for either side: mostly none, some short, a few long,
   // and now and then a calm stretch with no idling at all
   function automatic int idle_len(inout int calm);
      int pick;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (pick < 65) return 0;
      if (pick < 93) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   // result that is obvious by inspection: only status and size matter
   function automatic list_result_type typed_result(input logic [2:0] status,
                                                    input int size);
      list_result_type r;
      r = '0;
      r.status    = status;
      r.list_size = 9'(size);
      r.is_empty  = (size == 0);
      return r;
   endfunction

   function automatic stim_row_type dir_row(input logic [3:0] mode, input logic [15:0] pos,
                                            input logic [31:0] key, input logic [31:0] pay,
                                            input bit typed, input logic [2:0] status,
                                            input int size);
      stim_row_type r;
      r.mode  = mode;
      r.pos   = pos;
      r.key   = key;
      r.pay   = pay;
      r.typed = typed;
      r.want  = typed_result(status, size);
      return r;
   endfunction

   // list operation on the shadow copy; returns the result it should give
   function automatic list_result_type apply_list_op(input logic [3:0] mode,
                                                     input logic [15:0] pos,
                                                     input logic [31:0] key,
                                                     input logic [31:0] pay);
      list_result_type r;
      int i;
      int w;
      int at;
      int hits;
      r    = '0;
      hits = 0;
      case (mode)
         MODE_INS_FRONT, MODE_INS_END, MODE_INS_AT: begin
            if (shadow_count >= CAPACITY) begin
               r.status = STAT_FULL;
            end else begin
               if (mode == MODE_INS_FRONT) at = 0;
               else if (mode == MODE_INS_END) at = shadow_count;
               else at = pos;
               // past the end just appends
               if (at > shadow_count) at = shadow_count;
               for (i = shadow_count; i > at; i--) begin
                  shadow_keys[i] = shadow_keys[i-1];
                  shadow_pays[i] = shadow_pays[i-1];
               end
               shadow_keys[at] = key;
               shadow_pays[at] = pay;
               shadow_count++;
            end
         end
         MODE_RM_FRONT, MODE_RM_END, MODE_RM_AT: begin
            if (shadow_count == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               if (mode == MODE_RM_FRONT) at = 0;
               else if (mode == MODE_RM_END) at = shadow_count - 1;
               else at = pos;
               // past the end takes the last record
               if (at >= shadow_count) at = shadow_count - 1;
               for (i = at; i + 1 < shadow_count; i++) begin
                  shadow_keys[i] = shadow_keys[i+1];
                  shadow_pays[i] = shadow_pays[i+1];
               end
               shadow_count--;
            end
         end
         MODE_RM_KEY: begin
            if (shadow_count == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               w = 0;
               for (i = 0; i < shadow_count; i++) begin
                  if (shadow_keys[i] == key) begin
                     hits++;
                  end else begin
                     shadow_keys[w] = shadow_keys[i];
                     shadow_pays[w] = shadow_pays[i];
                     w++;
                  end
               end
               shadow_count  = w;
               r.match_count = 9'(hits);
               if (hits == 0) r.status = STAT_NOKEY;
            end
         end
         MODE_FIND: begin
            if (shadow_count == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               r.status = STAT_NOKEY;
               for (i = 0; i < shadow_count; i++) begin
                  if (shadow_keys[i] == key) begin
                     r.status      = STAT_OK;
                     r.found_index = 8'(i);
                     r.key_out     = shadow_keys[i];
                     r.payload_out = shadow_pays[i];
                     break;
                  end
               end
            end
         end
         MODE_READ: begin
            if (shadow_count == 0) begin
               r.status = STAT_EMPTY;
            end else if (pos >= shadow_count) begin
               r.status = STAT_BADPOS;
            end else begin
               r.key_out     = shadow_keys[pos];
               r.payload_out = shadow_pays[pos];
            end
         end
         MODE_CLEAR: begin
            shadow_count = 0;
         end
         default: begin
         end
      endcase
      r.list_size = 9'(shadow_count);
      r.is_empty  = (shadow_count == 0);
      return r;
   endfunction

   // present one request word, hold it until taken, then log what should come back
   task automatic send_word(input logic [3:0] mode, input logic [15:0] pos,
                            input logic [31:0] key, input logic [31:0] pay,
                            input bit typed, input list_result_type want);
      int gap;
      list_result_type predicted;
      gap = idle_len(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {pay, key, pos};
      do @(posedge clock); while (!req_tready);
      predicted = apply_list_op(mode, pos, key, pay);
      if (typed) pending_results.push_back(want);
      else pending_results.push_back(predicted);
   endtask

   // stop sending until every outstanding result is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // result side: random back-pressure, each word checked against the oldest entry
   initial begin
      int gap;
      logic [RSP_TDATA_W-1:0] word;
      list_result_type want;
      do @(posedge clock); while (reset);
      forever begin
         gap = idle_len(rsp_calm);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         word = rsp_tdata;
         words_checked++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result word", word[31:0], 32'd0);
         end else begin
            want = pending_results.pop_front();
            if (word[2:0] !== want.status)
               report_mismatch("status", 32'(word[2:0]), 32'(want.status));
            if (word[10:3] !== want.found_index)
               report_mismatch("found_index", 32'(word[10:3]), 32'(want.found_index));
            if (word[42:11] !== want.key_out)
               report_mismatch("key_out", word[42:11], want.key_out);
            if (word[74:43] !== want.payload_out)
               report_mismatch("payload_out", word[74:43], want.payload_out);
            if (word[83:75] !== want.match_count)
               report_mismatch("match_count", 32'(word[83:75]), 32'(want.match_count));
            if (word[92:84] !== want.list_size)
               report_mismatch("list_size", 32'(word[92:84]), 32'(want.list_size));
            if (word[93] !== want.is_empty)
               report_mismatch("is_empty", 32'(word[93]), 32'(want.is_empty));
            if (word[95:94] !== 2'b00)
               report_mismatch("padding", 32'(word[95:94]), 32'd0);
         end
      end
   end

   // hard limit well above the slowest legal run
   initial begin
      #10_000_000;
      $display("ordered_record_list_table_unit verification failed");
      $finish;
   end

   initial begin
      stim_row_type directed_rows [$];
      logic [31:0]  key_pool [6];
      logic [31:0]  fill_key;
      logic [31:0]  tail_key;
      logic [31:0]  k;
      logic [15:0]  p;
      logic [3:0]   m;
      int           w;
      int           n;

      // directed table: empty-list errors first, then extremes and edge positions
      directed_rows.push_back(dir_row(MODE_READ, 16'd0, 32'd0, 32'd0, 1, STAT_EMPTY, 0));
      directed_rows.push_back(dir_row(MODE_RM_FRONT, 16'd0, 32'd0, 32'd0, 1, STAT_EMPTY, 0));
      directed_rows.push_back(dir_row(MODE_RM_END, 16'd0, 32'd0, 32'd0, 1, STAT_EMPTY, 0));
      directed_rows.push_back(dir_row(MODE_RM_AT, 16'hffff, 32'd0, 32'd0, 1, STAT_EMPTY, 0));
      directed_rows.push_back(dir_row(MODE_RM_KEY, 16'd0, 32'd0, 32'd0, 1, STAT_EMPTY, 0));
      directed_rows.push_back(dir_row(MODE_FIND, 16'd0, 32'd0, 32'd0, 1, STAT_EMPTY, 0));
      directed_rows.push_back(dir_row(MODE_CLEAR, 16'd0, 32'd0, 32'd0, 1, STAT_OK, 0));
      directed_rows.push_back(dir_row(MODE_UNUSED_HI, 16'hffff, 32'hffff_ffff,
                                      32'hffff_ffff, 1, STAT_OK, 0));
      directed_rows.push_back(dir_row(MODE_INS_FRONT, 16'd0, 32'h8000_0000, 32'd0,
                                      1, STAT_OK, 1));
      directed_rows.push_back(dir_row(MODE_INS_END, 16'd0, 32'h7fff_ffff, 32'hffff_ffff,
                                      1, STAT_OK, 2));
      // position far past the end appends
      directed_rows.push_back(dir_row(MODE_INS_AT, 16'hffff, 32'hffff_ffff, 32'ha5a5_a5a5,
                                      1, STAT_OK, 3));
      directed_rows.push_back(dir_row(MODE_INS_AT, 16'd0, 32'd0, 32'h5a5a_5a5a, 1, STAT_OK, 4));
      directed_rows.push_back(dir_row(MODE_INS_AT, 16'd1, 32'd5, 32'h0000_1234, 1, STAT_OK, 5));
      directed_rows.push_back(dir_row(MODE_READ, 16'd0, 32'd0, 32'd0, 0, STAT_OK, 0));
      directed_rows.push_back(dir_row(MODE_READ, 16'hffff, 32'd0, 32'd0, 1, STAT_BADPOS, 5));
      directed_rows.push_back(dir_row(MODE_READ, 16'd5, 32'd0, 32'd0, 1, STAT_BADPOS, 5));
      directed_rows.push_back(dir_row(MODE_FIND, 16'd0, 32'h7fff_ffff, 32'd0, 0, STAT_OK, 0));
      directed_rows.push_back(dir_row(MODE_FIND, 16'd0, 32'd12345, 32'd0, 1, STAT_NOKEY, 5));
      directed_rows.push_back(dir_row(MODE_RM_KEY, 16'd0, 32'd12345, 32'd0, 1, STAT_NOKEY, 5));
      directed_rows.push_back(dir_row(MODE_INS_END, 16'd0, 32'd5, 32'hdead_0005, 0, STAT_OK, 0));
      // duplicate key, two records go at once
      directed_rows.push_back(dir_row(MODE_RM_KEY, 16'd0, 32'd5, 32'd0, 0, STAT_OK, 0));
      // remove position past the end takes the last record
      directed_rows.push_back(dir_row(MODE_RM_AT, 16'hffff, 32'd0, 32'd0, 0, STAT_OK, 0));
      directed_rows.push_back(dir_row(MODE_RM_AT, 16'd0, 32'd0, 32'd0, 0, STAT_OK, 0));
      directed_rows.push_back(dir_row(MODE_RM_FRONT, 16'd0, 32'd0, 32'd0, 0, STAT_OK, 0));
      directed_rows.push_back(dir_row(MODE_RM_END, 16'd0, 32'd0, 32'd0, 0, STAT_OK, 0));
      directed_rows.push_back(dir_row(MODE_UNUSED_LO, 16'd7, 32'd7, 32'd7, 1, STAT_OK, 0));

      // reset once at the start, then release
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].mode, directed_rows[i].pos, directed_rows[i].key,
                   directed_rows[i].pay, directed_rows[i].typed, directed_rows[i].want);
      drain_results();

      // fill to capacity with one key, last slot gets a different key
      fill_key = $urandom;
      tail_key = ~fill_key;
      for (n = 0; n < CAPACITY - 1; n++) begin
         m = 4'($urandom_range(MODE_INS_FRONT, MODE_INS_AT));
         if ($urandom_range(0, 9) == 0) p = 16'($urandom);
         else p = 16'($urandom_range(0, shadow_count + 2));
         send_word(m, p, fill_key, $urandom, 0, '0);
      end
      send_word(MODE_INS_END, 16'd0, tail_key, $urandom, 0, '0);
      // deepest find and read
      send_word(MODE_FIND, 16'd0, tail_key, 32'd0, 0, '0);
      send_word(MODE_READ, 16'(CAPACITY - 1), 32'd0, 32'd0, 0, '0);
      send_word(MODE_READ, 16'(CAPACITY), 32'd0, 32'd0, 1, typed_result(STAT_BADPOS, CAPACITY));
      // full list refuses every kind of insert
      send_word(MODE_INS_FRONT, 16'd0, $urandom, $urandom, 1,
                typed_result(STAT_FULL, CAPACITY));
      send_word(MODE_INS_END, 16'd0, $urandom, $urandom, 1, typed_result(STAT_FULL, CAPACITY));
      send_word(MODE_INS_AT, 16'($urandom), $urandom, $urandom, 1,
                typed_result(STAT_FULL, CAPACITY));
      send_word(MODE_RM_KEY, 16'd0, tail_key, 32'd0, 0, '0);
      send_word(MODE_INS_FRONT, 16'd0, fill_key, $urandom, 0, '0);
      // every record matches: largest count, list ends empty
      send_word(MODE_RM_KEY, 16'd0, fill_key, 32'd0, 0, '0);
      drain_results();

      // random mix, keys mostly from a small pool so searches hit
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7fff_ffff;
      key_pool[2] = 32'd0;
      key_pool[3] = 32'hffff_ffff;
      key_pool[4] = $urandom;
      key_pool[5] = $urandom;
      for (n = 0; n < 270; n++) begin
         w = $urandom_range(0, 99);
         if (w < 40) m = 4'($urandom_range(MODE_INS_FRONT, MODE_INS_AT));
         else if (w < 60) m = 4'($urandom_range(MODE_RM_FRONT, MODE_RM_AT));
         else if (w < 68) m = MODE_RM_KEY;
         else if (w < 80) m = MODE_FIND;
         else if (w < 92) m = MODE_READ;
         else if (w < 94) m = MODE_CLEAR;
         else m = 4'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
         if ($urandom_range(0, 3) == 0) k = $urandom;
         else k = key_pool[$urandom_range(0, 5)];
         w = $urandom_range(0, 99);
         if (w < 60) p = 16'($urandom_range(0, shadow_count + 1));
         else if (w < 85) p = 16'($urandom_range(0, 3));
         else p = 16'($urandom);
         send_word(m, p, k, $urandom, 0, '0);
         if (n == 135) drain_results();
      end

      drain_results();
      // let any stray word show up before the verdict
      repeat (300) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results never arrived", 32'(pending_results.size()), 32'd0);
      if (mismatch_count == 0) begin
         $display("ordered_record_list_table_unit verification clean");
      end else begin
         $display("ordered_record_list_table_unit verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
